/* rtl/obpq_pkg.sv */
// Package with the register map, reset values and fixed-point helpers of the oriented box query.
package obpq_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned HalfW  = 31;
  localparam int unsigned AxisW  = 16;
  localparam int unsigned FracAxis = 14;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned WideW  = 36;

  localparam logic [2:0] RegCenterX = 3'd0;
  localparam logic [2:0] RegCenterY = 3'd1;
  localparam logic [2:0] RegHalfX   = 3'd2;
  localparam logic [2:0] RegHalfY   = 3'd3;
  localparam logic [2:0] RegAxisCos = 3'd4;
  localparam logic [2:0] RegAxisSin = 3'd5;

  localparam logic signed [CoordW-1:0] ResetCenter = '0;
  localparam logic [HalfW-1:0]         ResetHalf   = 31'd65536;
  localparam logic signed [AxisW-1:0]  ResetCos    = 16'sd16384;
  localparam logic signed [AxisW-1:0]  ResetSin    = 16'sd0;

  localparam logic signed [CoordW-1:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] SatMin = 32'sh8000_0000;

  function automatic logic signed [CoordW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic hi_same;
    hi_same = (v[WideW-1:CoordW-1] == '0) || (v[WideW-1:CoordW-1] == '1);
    if (hi_same) begin
      return v[CoordW-1:0];
    end else if (v[WideW-1]) begin
      return SatMin;
    end else begin
      return SatMax;
    end
  endfunction

endpackage

/* rtl/oriented_box_point_query_top.sv */
// Top level of the oriented box point query: a seven stage pipeline with an APB register port.
//
//   channel   direction  handshake              payload
//   in_       slave      in_tvalid/in_tready    tdata: point_x, point_y
//   out_      master     out_tvalid/out_tready  tdata: local_x, local_y, closest_x, closest_y;
//                                               tuser: inside_res
//   cfg_      APB slave  psel/penable/pready    six box registers at byte address 4*i
//
// One point enters per cycle while the output is not held, and its result passes through the
// seven register stages; the two rows of multipliers each have their own register stage.
// Reset (synchronous, rst_n low) empties the pipeline and loads the unit box at the origin.
// When the output is held, the whole pipeline holds and in_tready drops; nothing is lost.
module oriented_box_point_query_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // point_x [31:0], point_y [63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [127:0] out_tdata,  // local_x, local_y, closest_x, closest_y
  output logic [0:0]  out_tuser,   // inside_res
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [obpq_pkg::AddrW-1:0] cfg_paddr,
  input  logic [obpq_pkg::DataW-1:0] cfg_pwdata,
  output logic [obpq_pkg::DataW-1:0] cfg_prdata,
  output logic        cfg_pready
);
  import obpq_pkg::*;

  localparam int unsigned Stages = 6;

  logic signed [CoordW-1:0] center_x_r, center_y_r;
  logic [HalfW-1:0]         half_x_r, half_y_r;
  logic signed [AxisW-1:0]  axis_cos_r, axis_sin_r;

  logic [2:0] reg_idx;
  logic       cfg_write;

  assign reg_idx    = cfg_paddr[AddrW-1:2];
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= ResetCenter;
      center_y_r <= ResetCenter;
      half_x_r   <= ResetHalf;
      half_y_r   <= ResetHalf;
      axis_cos_r <= ResetCos;
      axis_sin_r <= ResetSin;
    end else if (cfg_write) begin
      case (reg_idx)
        RegCenterX: center_x_r <= cfg_pwdata;
        RegCenterY: center_y_r <= cfg_pwdata;
        RegHalfX:   half_x_r   <= cfg_pwdata[HalfW-1:0];
        RegHalfY:   half_y_r   <= cfg_pwdata[HalfW-1:0];
        RegAxisCos: axis_cos_r <= cfg_pwdata[AxisW-1:0];
        RegAxisSin: axis_sin_r <= cfg_pwdata[AxisW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegCenterX: cfg_prdata = center_x_r;
      RegCenterY: cfg_prdata = center_y_r;
      RegHalfX:   cfg_prdata = {1'b0, half_x_r};
      RegHalfY:   cfg_prdata = {1'b0, half_y_r};
      RegAxisCos: cfg_prdata = {{(DataW-AxisW){axis_cos_r[AxisW-1]}}, axis_cos_r};
      RegAxisSin: cfg_prdata = {{(DataW-AxisW){axis_sin_r[AxisW-1]}}, axis_sin_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // Pipeline control: every stage moves together when the output register is empty or being taken.
  logic              en;
  logic [Stages-1:0] vld_r;
  logic              out_valid_r;

  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;

  logic signed [CoordW-1:0] px, py;
  assign px = in_tdata[31:0];
  assign py = in_tdata[63:32];

  // Stage 1: offsets from the center.
  logic signed [CoordW:0] dx_r, dy_r;
  // Stage 2: projections onto the axes.
  logic signed [CoordW+AxisW:0] p_xc_r, p_ys_r, p_yc_r, p_xs_r;
  // Stage 3: rounded local coordinates at full width.
  logic signed [WideW-1:0] lx_r, ly_r;
  logic signed [CoordW+AxisW+1:0] sum_lx, sum_ly;
  // Stage 4: clamp, inside test and saturated locals.
  logic signed [CoordW-1:0] cx_r, cy_r, loc_x4_r, loc_y4_r;
  logic                     inside4_r;
  logic signed [WideW-1:0]  hx_w, hy_w, cx_w, cy_w;
  // Stage 5: back-rotation products.
  logic signed [CoordW+AxisW-1:0] q_xc_r, q_ys_r, q_xs_r, q_yc_r;
  logic signed [CoordW-1:0] loc_x5_r, loc_y5_r;
  logic                     inside5_r;
  // Stage 6: rounded world offsets.
  logic signed [CoordW+AxisW:0] sum_wx, sum_wy;
  logic signed [CoordW+2:0] rx_r, ry_r;
  logic signed [CoordW-1:0] loc_x6_r, loc_y6_r;
  logic                     inside6_r;
  // Stage 7: output register.
  logic signed [CoordW-1:0] out_lx_r, out_ly_r, out_cx_r, out_cy_r;
  logic                     out_in_r;
  logic signed [WideW-1:0]  wx, wy;

  assign sum_ly = $signed({p_yc_r[CoordW+AxisW], p_yc_r})
                - $signed({p_xs_r[CoordW+AxisW], p_xs_r}) + 50'sd8192;
  assign sum_lx = $signed({p_xc_r[CoordW+AxisW], p_xc_r})
                + $signed({p_ys_r[CoordW+AxisW], p_ys_r}) + 50'sd8192;

  assign hx_w = $signed({{(WideW-HalfW){1'b0}}, half_x_r});
  assign hy_w = $signed({{(WideW-HalfW){1'b0}}, half_y_r});

  always_comb begin
    if (lx_r > hx_w) begin
      cx_w = hx_w;
    end else if (lx_r < -hx_w) begin
      cx_w = -hx_w;
    end else begin
      cx_w = lx_r;
    end
    if (ly_r > hy_w) begin
      cy_w = hy_w;
    end else if (ly_r < -hy_w) begin
      cy_w = -hy_w;
    end else begin
      cy_w = ly_r;
    end
  end

  assign sum_wx = $signed({q_xc_r[CoordW+AxisW-1], q_xc_r})
                - $signed({q_ys_r[CoordW+AxisW-1], q_ys_r}) + 49'sd8192;
  assign sum_wy = $signed({q_xs_r[CoordW+AxisW-1], q_xs_r})
                + $signed({q_yc_r[CoordW+AxisW-1], q_yc_r}) + 49'sd8192;

  assign wx = $signed({{(WideW-CoordW){center_x_r[CoordW-1]}}, center_x_r})
            + $signed({rx_r[CoordW+2], rx_r});
  assign wy = $signed({{(WideW-CoordW){center_y_r[CoordW-1]}}, center_y_r})
            + $signed({ry_r[CoordW+2], ry_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[Stages-2:0], in_tvalid};
      out_valid_r <= vld_r[Stages-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= $signed({px[CoordW-1], px}) - $signed({center_x_r[CoordW-1], center_x_r});
      dy_r <= $signed({py[CoordW-1], py}) - $signed({center_y_r[CoordW-1], center_y_r});

      p_xc_r <= dx_r * axis_cos_r;
      p_ys_r <= dy_r * axis_sin_r;
      p_yc_r <= dy_r * axis_cos_r;
      p_xs_r <= dx_r * axis_sin_r;

      lx_r <= sum_lx[CoordW+AxisW+1:FracAxis];
      ly_r <= sum_ly[CoordW+AxisW+1:FracAxis];

      cx_r      <= cx_w[CoordW-1:0];
      cy_r      <= cy_w[CoordW-1:0];
      loc_x4_r  <= sat32(lx_r);
      loc_y4_r  <= sat32(ly_r);
      inside4_r <= (lx_r < hx_w) && (lx_r > -hx_w) && (ly_r < hy_w) && (ly_r > -hy_w);

      q_xc_r    <= cx_r * axis_cos_r;
      q_ys_r    <= cy_r * axis_sin_r;
      q_xs_r    <= cx_r * axis_sin_r;
      q_yc_r    <= cy_r * axis_cos_r;
      loc_x5_r  <= loc_x4_r;
      loc_y5_r  <= loc_y4_r;
      inside5_r <= inside4_r;

      rx_r      <= sum_wx[CoordW+AxisW:FracAxis];
      ry_r      <= sum_wy[CoordW+AxisW:FracAxis];
      loc_x6_r  <= loc_x5_r;
      loc_y6_r  <= loc_y5_r;
      inside6_r <= inside5_r;

      out_lx_r <= loc_x6_r;
      out_ly_r <= loc_y6_r;
      out_in_r <= inside6_r;
      out_cx_r <= sat32(wx);
      out_cy_r <= sat32(wy);
    end
  end

  assign out_tdata = {out_cy_r, out_cx_r, out_ly_r, out_lx_r};
  assign out_tuser = out_in_r;

endmodule
